>>> design/frdm_pkg.sv
// ----------------------------------------------------------------------------
// frdm_pkg: shared types and constants of the frame RMS / dialnorm meter
// Holds widths, the dB threshold table, the controller state type and the
// lane control struct.
// ----------------------------------------------------------------------------
package frdm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_FRAME   = 8192;
  localparam int LEN_W       = 14;
  localparam int SQ_W        = 2 * SAMPLE_BITS - 1;
  localparam int ENERGY_W    = 44;
  localparam int E_W         = ENERGY_W + 1;
  localparam int NORM_SHIFT  = 62 - 2 * SAMPLE_BITS;
  localparam int DVD_W       = E_W + NORM_SHIFT;
  localparam int DVS_W       = 32;
  localparam int CNT_W       = 7;
  localparam int MS_W        = 61;
  localparam int P_W         = 64;
  localparam int LVL_W       = 7;
  localparam int GATE_W      = 32;

  localparam logic [LVL_W-1:0] LVL_SILENT = 7'd100;
  localparam logic [LVL_W-1:0] LVL_LAST_K = 7'd99;
  localparam logic [LVL_W-1:0] GATE_LO    = 7'd15;
  localparam logic [LVL_W-1:0] GATE_HI    = 7'd40;
  localparam logic [LVL_W-1:0] DN_MAX     = 7'd31;
  localparam logic [P_W-1:0]   Q60_ONE    = 64'h1000_0000_0000_0000;

  localparam logic RES_LEVEL = 1'b0;
  localparam logic RES_DIALN = 1'b1;
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_LEN   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLOSE, S_DIV, S_LOG, S_EMIT_LVL, S_DN_START, S_DN_DIV, S_EMIT_DN
  } state_t;

  typedef struct packed {
    logic accumulate;
    logic clear;
  } lane_ctl_t;

  // 10^(-(b+0.5)/10) in Q30, moved to Q60 for the compare
  function automatic logic [P_W-1:0] thr_q60(input logic [3:0] b);
    logic [31:0] t;
    case (b)
      4'd0:    t = 32'd956973408;
      4'd1:    t = 32'd760150997;
      4'd2:    t = 32'd603809400;
      4'd3:    t = 32'd479622855;
      4'd4:    t = 32'd380977975;
      4'd5:    t = 32'd302621563;
      4'd6:    t = 32'd240380852;
      4'd7:    t = 32'd190941298;
      4'd8:    t = 32'd151670064;
      default: t = 32'd120475814;
    endcase
    return {2'b00, t, 30'b0};
  endfunction

endpackage

>>> design/frame_rms_dialnorm_meter_top.sv
// ----------------------------------------------------------------------------
// frame_rms_dialnorm_meter_top: frame RMS level meter with dialnorm estimate
// A sample item that does not close a frame is summed into the lanes. A
// frame close runs the serial divider for the mean square and then the dB
// threshold search, both skipped for a frame of zero energy.
// A stream-end item adds a second divider pass for dialnorm.
// Input is taken only while the controller is idle; a finished result sits
// in the output register while the next sample is taken.
// ----------------------------------------------------------------------------
module frame_rms_dialnorm_meter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // left_sample[15:0], right_sample[31:16]
  input  logic        s_tlast,   // stream_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // level_db[6:0], zero pad[7]
  output logic        m_tuser,   // result_kind
  output logic        m_tlast,   // last_result
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [13:0] cfg_data
);

  frdm_pkg::state_t state, state_next;

  logic                             stereo_mode;
  logic [frdm_pkg::LEN_W-1:0]       frame_length;
  logic [frdm_pkg::LEN_W-1:0]       eff_len;
  logic [frdm_pkg::LEN_W-1:0]       frame_count;
  logic [frdm_pkg::LEN_W-1:0]       count_inc;
  logic [frdm_pkg::GATE_W-1:0]      gated_sum;
  logic [frdm_pkg::GATE_W-1:0]      gated_count;
  logic [frdm_pkg::GATE_W:0]        sum_ext;
  logic [frdm_pkg::LVL_W-1:0]       lvl;
  logic                             is_end;
  logic [frdm_pkg::ENERGY_W-1:0]    left_energy, right_energy;
  logic [frdm_pkg::E_W-1:0]         energy;
  logic [frdm_pkg::LEN_W:0]         n_eff;
  frdm_pkg::lane_ctl_t              lane_ctl;
  logic                             accept, slot_free;
  logic                             div_start, div_busy, div_sel_dn;
  logic [frdm_pkg::DVD_W-1:0]       div_dvd, div_quot;
  logic [frdm_pkg::DVS_W-1:0]       div_dvs;
  logic                             log_start, log_busy;
  logic [frdm_pkg::LVL_W-1:0]       log_lvl;
  logic [frdm_pkg::LVL_W-1:0]       dn_val;
  logic                             out_load, out_kind, out_last;
  logic [frdm_pkg::LVL_W-1:0]       out_lvl;
  logic                             emit_lvl, clear_stream, gate_hit;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == frdm_pkg::S_IDLE);
  assign slot_free = !m_tvalid || m_tready;
  assign count_inc = frame_count + 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_mode  <= 1'b1;
      frame_length <= 14'd2400;
    end else if (cfg_we) begin
      unique case (cfg_index)
        frdm_pkg::REG_MODE: stereo_mode  <= cfg_data[0];
        frdm_pkg::REG_LEN:  frame_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the frame length to 1..MAX_FRAME
  always_comb begin
    eff_len = frame_length;
    if (frame_length == '0) begin
      eff_len = 14'd1;
    end else if (frame_length > frdm_pkg::LEN_W'(frdm_pkg::MAX_FRAME)) begin
      eff_len = frdm_pkg::LEN_W'(frdm_pkg::MAX_FRAME);
    end
  end

  // channel lanes
  frdm_lane u_lane_l (
    .clk(clk), .rst(rst), .ctl(lane_ctl),
    .sample(s_tdata[15:0]), .energy(left_energy)
  );
  frdm_lane u_lane_r (
    .clk(clk), .rst(rst), .ctl(lane_ctl),
    .sample(s_tdata[31:16]), .energy(right_energy)
  );

  // merge the lanes by mode
  always_comb begin
    if (stereo_mode) begin
      energy = {1'b0, left_energy} + {1'b0, right_energy};
      n_eff  = {frame_count, 1'b0};
    end else begin
      energy = {1'b0, left_energy};
      n_eff  = {1'b0, frame_count};
    end
  end

  // shared divider: mean square or dialnorm
  assign div_dvd = div_sel_dn ? frdm_pkg::DVD_W'(gated_sum)
                              : {energy, {frdm_pkg::NORM_SHIFT{1'b0}}};
  assign div_dvs = div_sel_dn ? gated_count : frdm_pkg::DVS_W'(n_eff);

  frdm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .busy(div_busy), .quot(div_quot)
  );

  frdm_log u_log (
    .clk(clk), .rst(rst), .start(log_start), .ms(div_quot[frdm_pkg::MS_W-1:0]),
    .busy(log_busy), .lvl(log_lvl)
  );

  assign dn_val = (div_quot[frdm_pkg::DVD_W-1:5] != '0) ? frdm_pkg::DN_MAX
                                                        : {2'b00, div_quot[4:0]};
  assign gate_hit = (lvl < frdm_pkg::GATE_HI) && (lvl > frdm_pkg::GATE_LO);
  assign sum_ext  = {1'b0, gated_sum} + (frdm_pkg::GATE_W + 1)'(lvl);

  // controller next state and strobes
  always_comb begin
    state_next          = state;
    lane_ctl.accumulate = 1'b0;
    lane_ctl.clear      = 1'b0;
    div_start           = 1'b0;
    div_sel_dn          = 1'b0;
    log_start           = 1'b0;
    out_load            = 1'b0;
    out_kind            = frdm_pkg::RES_LEVEL;
    out_lvl             = lvl;
    out_last            = 1'b0;
    emit_lvl            = 1'b0;
    clear_stream        = 1'b0;
    unique case (state)
      frdm_pkg::S_IDLE: begin
        if (accept) begin
          if (s_tlast) begin
            state_next = (frame_count != '0) ? frdm_pkg::S_CLOSE : frdm_pkg::S_DN_START;
          end else begin
            lane_ctl.accumulate = 1'b1;
            if (count_inc >= eff_len) begin
              state_next = frdm_pkg::S_CLOSE;
            end
          end
        end
      end
      frdm_pkg::S_CLOSE: begin
        if (energy == '0) begin
          state_next = frdm_pkg::S_EMIT_LVL;
        end else begin
          div_start  = 1'b1;
          state_next = frdm_pkg::S_DIV;
        end
      end
      frdm_pkg::S_DIV: begin
        if (!div_busy) begin
          log_start  = 1'b1;
          state_next = frdm_pkg::S_LOG;
        end
      end
      frdm_pkg::S_LOG: begin
        if (!log_busy) begin
          state_next = frdm_pkg::S_EMIT_LVL;
        end
      end
      frdm_pkg::S_EMIT_LVL: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_last       = !is_end;
          emit_lvl       = 1'b1;
          lane_ctl.clear = 1'b1;
          state_next     = is_end ? frdm_pkg::S_DN_START : frdm_pkg::S_IDLE;
        end
      end
      frdm_pkg::S_DN_START: begin
        div_sel_dn = 1'b1;
        div_start  = 1'b1;
        state_next = frdm_pkg::S_DN_DIV;
      end
      frdm_pkg::S_DN_DIV: begin
        if (!div_busy) begin
          state_next = frdm_pkg::S_EMIT_DN;
        end
      end
      frdm_pkg::S_EMIT_DN: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_kind       = frdm_pkg::RES_DIALN;
          out_lvl        = dn_val;
          out_last       = 1'b1;
          clear_stream   = 1'b1;
          lane_ctl.clear = 1'b1;
          state_next     = frdm_pkg::S_IDLE;
        end
      end
      default: state_next = frdm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frdm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // frame counter and stream-end flag
  always_ff @(posedge clk) begin
    if (rst || emit_lvl || clear_stream) begin
      frame_count <= '0;
    end else if (lane_ctl.accumulate) begin
      frame_count <= count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_end <= 1'b0;
    end else if (accept) begin
      is_end <= s_tlast;
    end
  end

  // hold the frame level
  always_ff @(posedge clk) begin
    if (state == frdm_pkg::S_CLOSE) begin
      lvl <= frdm_pkg::LVL_SILENT;
    end else if (state == frdm_pkg::S_LOG && !log_busy) begin
      lvl <= log_lvl;
    end
  end

  // gated sum and count, saturating
  always_ff @(posedge clk) begin
    if (rst || clear_stream) begin
      gated_sum   <= '0;
      gated_count <= 32'd1;
    end else if (emit_lvl && gate_hit) begin
      gated_sum <= sum_ext[frdm_pkg::GATE_W] ? '1 : sum_ext[frdm_pkg::GATE_W-1:0];
      if (gated_count != '1) begin
        gated_count <= gated_count + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, out_lvl};
      m_tuser <= out_kind;
      m_tlast <= out_last;
    end
  end

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_log_idle: assert property (@(posedge clk) disable iff (rst)
    log_start |-> !log_busy) else $error("search restarted while busy");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    frame_count <= frdm_pkg::LEN_W'(frdm_pkg::MAX_FRAME))
    else $error("frame count beyond maximum frame");
  a_gate_nz: assert property (@(posedge clk) disable iff (rst)
    gated_count != '0) else $error("gated count reached zero");
  a_slot: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready)) else $error("result overwritten");

endmodule

>>> design/frdm_lane.sv
// ----------------------------------------------------------------------------
// frdm_lane: one channel lane
// Squares the incoming sample and sums it into the channel energy.
// ----------------------------------------------------------------------------
module frdm_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  frdm_pkg::lane_ctl_t                 ctl,
  input  logic [frdm_pkg::SAMPLE_BITS-1:0]    sample,
  output logic [frdm_pkg::ENERGY_W-1:0]       energy
);

  logic signed [2*frdm_pkg::SAMPLE_BITS-1:0] sq_full;
  logic [frdm_pkg::SQ_W-1:0]                 sq;

  // square of the two's complement sample, at most 2^(2*SAMPLE_BITS-2)
  assign sq_full = $signed(sample) * $signed(sample);
  assign sq      = sq_full[frdm_pkg::SQ_W-1:0];

  // accumulate or clear the energy
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      energy <= '0;
    end else if (ctl.accumulate) begin
      energy <= energy + frdm_pkg::ENERGY_W'(sq);
    end
  end

endmodule

>>> design/frdm_div.sv
// ----------------------------------------------------------------------------
// frdm_div: serial restoring divider
// One quotient bit per cycle; shared by the mean-square and dialnorm paths.
// ----------------------------------------------------------------------------
module frdm_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [frdm_pkg::DVD_W-1:0]       dividend,
  input  logic [frdm_pkg::DVS_W-1:0]       divisor,
  output logic                             busy,
  output logic [frdm_pkg::DVD_W-1:0]       quot
);

  logic [frdm_pkg::DVS_W-1:0] rem;
  logic [frdm_pkg::DVS_W-1:0] dvs;
  logic [frdm_pkg::CNT_W-1:0] cnt;
  logic [frdm_pkg::DVS_W:0]   sh;
  logic [frdm_pkg::DVS_W:0]   diff;
  logic                       ge;

  // trial subtract of the shifted remainder
  assign sh   = {rem, quot[frdm_pkg::DVD_W-1]};
  assign diff = sh - {1'b0, dvs};
  assign ge   = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  // advance one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvs  <= divisor;
      quot <= dividend;
      cnt  <= frdm_pkg::CNT_W'(frdm_pkg::DVD_W - 1);
    end else if (busy) begin
      rem  <= ge ? diff[frdm_pkg::DVS_W-1:0] : sh[frdm_pkg::DVS_W-1:0];
      quot <= {quot[frdm_pkg::DVD_W-2:0], ge};
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

>>> design/frdm_log.sv
// ----------------------------------------------------------------------------
// frdm_log: dB threshold search
// Walks k = 1..99 one step per cycle and keeps the last k whose scaled
// mean square stays under the half-dB threshold.
// ----------------------------------------------------------------------------
module frdm_log (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [frdm_pkg::MS_W-1:0]      ms,
  output logic                           busy,
  output logic [frdm_pkg::LVL_W-1:0]     lvl
);

  logic [frdm_pkg::P_W-1:0]   p;
  logic [frdm_pkg::P_W-1:0]   p_use;
  logic [frdm_pkg::LVL_W-1:0] k;
  logic [3:0]                 d;

  // scale by ten at each decade while the value is still small
  always_comb begin
    p_use = p;
    if (d == 4'd0 && p <= frdm_pkg::Q60_ONE) begin
      p_use = (p << 3) + (p << 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && k == frdm_pkg::LVL_LAST_K) begin
      busy <= 1'b0;
    end
  end

  // step through the thresholds
  always_ff @(posedge clk) begin
    if (start) begin
      p   <= frdm_pkg::P_W'(ms);
      k   <= 7'd1;
      d   <= 4'd1;
      lvl <= '0;
    end else if (busy) begin
      p <= p_use;
      if (p_use <= frdm_pkg::thr_q60(d)) begin
        lvl <= k;
      end
      k <= k + 1'b1;
      d <= (d == 4'd9) ? 4'd0 : d + 4'd1;
    end
  end

endmodule
